// ===== hw/rtl/sbdb_pkg.sv =====
`timescale 1ns / 1ps

package sbdb_pkg;

    // Default transform length and fixed scaling constants.
    localparam int TRANSFORM_LENGTH_DEF = 256;
    localparam longint unsigned FULL_SCALE = 64'd32767;
    localparam int DB_PER_LOG2_Q16 = 197283;
    localparam logic [6:0] NOISE_FLOOR_RESET = 7'd90;

    // Result queue between the compute pipeline and the output stage.
    localparam int QUEUE_DEPTH = 32;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // A finished display sample leaving the compute pipeline.
    typedef struct packed {
        logic               valid;
        logic signed [15:0] sample;
    } t_item;

    // Head of the result queue and its fill status.
    typedef struct packed {
        logic               valid;
        logic               full;
        logic signed [15:0] sample;
    } t_head;

    // Truncated log2 in Q6.16 of a constant, evaluated at elaboration.
    function automatic logic [21:0] log2_q16_const(input logic [63:0] x);
        int          e;
        logic [63:0] m;
        logic [15:0] frac;
        e = 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                e = i;
            end
        end
        if (e >= 30) begin
            m = x >> (e - 30);
        end else begin
            m = x << (30 - e);
        end
        frac = '0;
        for (int i = 1; i <= 16; i++) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac[16 - i] = 1'b1;
            end
        end
        return {e[5:0], frac};
    endfunction

endpackage

// ===== hw/rtl/spectrum_bin_to_db_display.sv =====
`timescale 1ns / 1ps

// Spectrum bin to dB display sample.
// Input channel: i_valid / o_stall with i_bin_real and i_bin_imag, one complex
// bin of an unscaled transform per transfer. Output channel: o_valid / i_stall
// with o_display_sample and o_second_copy. Each bin yields two transfers of the
// same sample; the second has o_second_copy set.
// The noise floor register is written with i_cfg_we / i_cfg_data; the user must
// do so only while idle, as the block itself does not enforce it. The compute
// pipeline holds power, a 16-stage log2 squaring chain, dB scaling, a 16-stage
// divide by the floor and the offset to a display sample.
// The output register sends two results per bin, so it takes a new bin only
// after the second copy of the last one has transferred. Up to 32 bins may be
// in flight or queued; beyond that o_stall rises until the output side pops
// the result queue. When the receiver stalls, the output holds and the queue
// absorbs results; the input stalls only once all 32 credits are taken.
// Synchronous reset empties the pipeline and queue and sets the noise floor
// to 90 dB.
module spectrum_bin_to_db_display #(
    parameter int TRANSFORM_LENGTH = sbdb_pkg::TRANSFORM_LENGTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [27:0] i_bin_real,
    input  logic signed [27:0] i_bin_imag,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_display_sample,
    output logic               o_second_copy
);
    import sbdb_pkg::*;

    logic [6:0] r_noise_floor;
    t_item      w_item;
    t_head      w_head;
    logic       w_pop;

    // Noise floor register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_floor <= NOISE_FLOOR_RESET;
        end else if (i_cfg_we) begin
            r_noise_floor <= i_cfg_data;
        end
    end

    sbdb_front #(
        .TRANSFORM_LENGTH(TRANSFORM_LENGTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_bin_real    (i_bin_real),
        .i_bin_imag    (i_bin_imag),
        .i_noise_floor (r_noise_floor),
        .i_release     (w_pop),
        .o_item        (w_item)
    );

    sbdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    sbdb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_display_sample (o_display_sample),
        .o_second_copy    (o_second_copy)
    );

    // The credit scheme must never let a result arrive at a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item.valid |-> !w_head.full)
        else $error("result pushed into a full queue");

    // A first copy that transfers is followed by its repeat.
    a_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_second_copy && !i_stall) |=>
        (o_valid && o_second_copy && o_display_sample == $past(o_display_sample)))
        else $error("second copy missing or changed");

    // A pop only happens when the queue holds a result.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/sbdb_front.sv =====
`timescale 1ns / 1ps

module sbdb_front #(
    parameter int TRANSFORM_LENGTH = sbdb_pkg::TRANSFORM_LENGTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [27:0]   i_bin_real,
    input  logic signed [27:0]   i_bin_imag,
    input  logic [6:0]           i_noise_floor,
    input  logic                 i_release,
    output sbdb_pkg::t_item      o_item
);
    import sbdb_pkg::*;

    localparam logic [63:0] FULL_AMP = 64'(TRANSFORM_LENGTH) * FULL_SCALE;
    localparam logic [21:0] LOG_Q = log2_q16_const(FULL_AMP * FULL_AMP);
    localparam logic signed [42:0] DB_SCALE = 43'(DB_PER_LOG2_Q16);
    localparam logic signed [42:0] DB_ROUND = 43'sd8388608;

    // Credit count: items in flight plus items waiting in the queue.
    logic [QUEUE_AW:0] r_used;
    logic [QUEUE_AW:0] n_used;
    logic              w_accept;

    assign o_stall  = (r_used == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_used = r_used;
        if (w_accept && !i_release) begin
            n_used = r_used + 1'b1;
        end else if (!w_accept && i_release) begin
            n_used = r_used - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    // Stage 0: magnitudes of both parts.
    logic        r_v0;
    logic [27:0] r_re;
    logic [27:0] r_im;

    // Stage 1: squares.
    logic        r_v1;
    logic [55:0] r_sq_re;
    logic [55:0] r_sq_im;

    // Stage 2: power.
    logic        r_v2;
    logic [55:0] r_pow;

    // Stage 3: leading one position.
    logic        r_v3;
    logic [55:0] r_pow3;
    logic [5:0]  r_exp;
    logic        r_zero3;
    logic [5:0]  w_exp;

    always_comb begin
        w_exp = '0;
        for (int i = 0; i < 56; i++) begin
            if (r_pow[i]) begin
                w_exp = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= w_accept;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_re    <= i_bin_real[27] ? 28'(-i_bin_real) : 28'(i_bin_real);
        r_im    <= i_bin_imag[27] ? 28'(-i_bin_imag) : 28'(i_bin_imag);
        r_sq_re <= 56'(r_re) * 56'(r_re);
        r_sq_im <= 56'(r_im) * 56'(r_im);
        r_pow   <= r_sq_re + r_sq_im;
        r_pow3  <= r_pow;
        r_exp   <= w_exp;
        r_zero3 <= (r_pow == '0);
    end

    // Log2 fraction: one squaring of the mantissa per stage.
    logic        r_lv [0:16];
    logic [30:0] r_lm [0:16];
    logic [15:0] r_lf [0:16];
    logic [5:0]  r_le [0:16];
    logic        r_lz [0:16];
    logic [85:0] w_norm;

    assign w_norm = {r_pow3, 30'b0} >> r_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv[0] <= 1'b0;
        end else begin
            r_lv[0] <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lm[0] <= w_norm[30:0];
        r_lf[0] <= '0;
        r_le[0] <= r_exp;
        r_lz[0] <= r_zero3;
    end

    for (genvar k = 0; k < 16; k++) begin : g_log
        logic [61:0] w_sq;
        logic [31:0] w_t;
        logic [15:0] w_f;

        assign w_sq = 62'(r_lm[k]) * 62'(r_lm[k]);
        assign w_t  = w_sq[61:30];

        always_comb begin
            w_f = r_lf[k];
            w_f[15 - k] = w_t[31];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lv[k + 1] <= 1'b0;
            end else begin
                r_lv[k + 1] <= r_lv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_lm[k + 1] <= w_t[31] ? w_t[31:1] : w_t[30:0];
            r_lf[k + 1] <= w_f;
            r_le[k + 1] <= r_le[k];
            r_lz[k + 1] <= r_lz[k];
        end
    end

    // Level relative to full scale, then conversion to dB in Q8.8.
    logic               r_dv;
    logic signed [23:0] r_d;
    logic               r_dz;
    logic               r_bv;
    logic signed [18:0] r_db;
    logic               r_bz;
    logic signed [42:0] w_dx;
    logic signed [42:0] w_prod;

    assign w_dx   = 43'(r_d);
    assign w_prod = w_dx * DB_SCALE + DB_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_bv <= 1'b0;
        end else begin
            r_dv <= r_lv[16];
            r_bv <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d  <= $signed({2'b0, r_le[16], r_lf[16]}) - $signed({2'b0, LOG_Q});
        r_dz <= r_lz[16];
        r_db <= w_prod[42:24];
        r_bz <= r_dz;
    end

    // Clamp at the floor and scale by 65535 ahead of the divide.
    logic [6:0]         w_floor;
    logic [14:0]        w_fq;
    logic signed [20:0] w_s;
    logic               w_low;
    logic               w_sat;
    logic [14:0]        w_cl;
    logic [30:0]        w_num;

    assign w_floor = (i_noise_floor == '0) ? 7'd1 : i_noise_floor;
    assign w_fq    = {w_floor, 8'b0};
    assign w_s     = 21'(r_db) + $signed({6'b0, w_fq});
    assign w_low   = r_bz || w_s[20];
    assign w_sat   = !w_low && (w_s[19:0] >= {5'b0, w_fq});
    assign w_cl    = w_low ? '0 : w_s[14:0];
    assign w_num   = {w_cl, 16'b0} - {16'b0, w_cl};

    // Restoring divide by the floor in Q8.8, one quotient bit per stage.
    logic        r_qv   [0:16];
    logic [30:0] r_rem  [0:16];
    logic [15:0] r_q    [0:16];
    logic        r_qsat [0:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv[0] <= 1'b0;
        end else begin
            r_qv[0] <= r_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= w_num;
        r_q[0]    <= '0;
        r_qsat[0] <= w_sat;
    end

    for (genvar k = 0; k < 16; k++) begin : g_div
        logic [30:0] w_dsh;
        logic        w_ge;
        logic [15:0] w_qn;

        assign w_dsh = 31'(w_fq) << (15 - k);
        assign w_ge  = (r_rem[k] >= w_dsh);

        always_comb begin
            w_qn = r_q[k];
            w_qn[15 - k] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[k + 1] <= 1'b0;
            end else begin
                r_qv[k + 1] <= r_qv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k + 1]  <= w_ge ? (r_rem[k] - w_dsh) : r_rem[k];
            r_q[k + 1]    <= w_qn;
            r_qsat[k + 1] <= r_qsat[k];
        end
    end

    // Offset to a signed display sample with saturation at the top.
    logic               r_ov;
    logic signed [15:0] r_osample;
    logic [16:0]        w_wave;

    assign w_wave = 17'(r_q[16]) - 17'd32767;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_qv[16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_osample <= r_qsat[16] ? 16'sd32767 : $signed(w_wave[15:0]);
    end

    assign o_item.valid  = r_ov;
    assign o_item.sample = r_osample;

endmodule

// ===== hw/rtl/sbdb_queue.sv =====
`timescale 1ns / 1ps

module sbdb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sbdb_pkg::t_item i_item,
    input  logic            i_pop,
    output sbdb_pkg::t_head o_head
);
    import sbdb_pkg::*;

    logic signed [15:0] r_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                w_pop;

    // The pipeline only pushes when it holds a credit, so room is guaranteed.
    assign w_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_item.valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_item.valid && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_item.valid && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_item.valid) begin
            r_mem[r_wp] <= i_item.sample;
        end
    end

    assign o_head.valid  = (r_cnt != '0);
    assign o_head.full   = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_head.sample = r_mem[r_rp];

endmodule

// ===== hw/rtl/sbdb_back.sv =====
`timescale 1ns / 1ps

module sbdb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbdb_pkg::t_head    i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_display_sample,
    output logic               o_second_copy
);
    import sbdb_pkg::*;

    logic               r_valid;
    logic               r_second;
    logic signed [15:0] r_sample;
    logic               w_free;

    // The output register can take a new value when empty or transferring.
    assign w_free = !r_valid || !i_stall;
    assign o_pop  = w_free && !(r_valid && !r_second) && i_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (w_free) begin
            if (r_valid && !r_second) begin
                r_second <= 1'b1;
            end else if (i_head.valid) begin
                r_valid  <= 1'b1;
                r_second <= 1'b0;
            end else begin
                r_valid  <= 1'b0;
                r_second <= 1'b0;
            end
        end
    end

    // Sample is loaded once per bin and repeated for the second copy.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample <= i_head.sample;
        end
    end

    assign o_valid          = r_valid;
    assign o_second_copy    = r_second;
    assign o_display_sample = r_sample;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int TRANSFORM_LENGTH = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY = 60;

    // Expected output transfer.
    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } t_display;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [6:0]         i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [27:0] i_bin_real;
    logic signed [27:0] i_bin_imag;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_display_sample;
    logic               o_second_copy;

    t_display    display_q[$];
    logic [6:0]  floor_reg;
    longint      full_log2;
    bit          idle_on;
    int          errors;
    int          cycles;
    int          bins_sent;
    int          samples_seen;
    int          stall_left;

    spectrum_bin_to_db_display #(
        .TRANSFORM_LENGTH(TRANSFORM_LENGTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_bin_real      (i_bin_real),
        .i_bin_imag      (i_bin_imag),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_display_sample(o_display_sample),
        .o_second_copy   (o_second_copy)
    );

    always #5 i_clk = ~i_clk;

    // Truncated log2 in Q6.16 by repeated squaring of the mantissa.
    function automatic longint log2_fixed(input longint unsigned x);
        int              e;
        longint unsigned m;
        longint unsigned frac;
        e = 63;
        while (e > 0 && x[e] == 1'b0) begin
            e--;
        end
        if (e >= 30) begin
            m = x >> (e - 30);
        end else begin
            m = x << (30 - e);
        end
        frac = 0;
        for (int i = 1; i <= 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | (64'd1 << (16 - i));
            end
        end
        return longint'((longint'(e) << 16) | frac);
    endfunction

    // Display sample for one bin at the current noise floor.
    function automatic logic signed [15:0] bin_to_display(input logic signed [27:0] re,
                                                          input logic signed [27:0] im);
        longint unsigned are;
        longint unsigned aim;
        longint unsigned power;
        longint          floor_q8;
        longint          level_q8;
        longint          scaled;
        longint          wave;
        are = (re < 0) ? longint'(-longint'(re)) : longint'(re);
        aim = (im < 0) ? longint'(-longint'(im)) : longint'(im);
        power = are * are + aim * aim;
        floor_q8 = ((floor_reg == 0) ? 1 : longint'(floor_reg)) * 256;
        if (power == 0) begin
            level_q8 = -floor_q8;
        end else begin
            // Round to nearest in Q8.8, floor division on negative levels.
            level_q8 = ((log2_fixed(power) - full_log2) * 197283 + (64'sd1 <<< 23)) >>> 24;
            if (level_q8 < -floor_q8) begin
                level_q8 = -floor_q8;
            end
        end
        scaled = (65535 * (level_q8 + floor_q8)) / floor_q8;
        wave = scaled - 32767;
        if (wave > 32767) begin
            wave = 32767;
        end
        return wave[15:0];
    endfunction

    task automatic report(input string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stall in random bursts, changed at the falling edge.
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Each output transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_display want;
        if (i_rst_n && o_valid && !i_stall) begin
            samples_seen++;
            if (display_q.size() == 0) begin
                report($sformatf("unexpected sample %0d", o_display_sample));
            end else begin
                want = display_q.pop_front();
                if (o_display_sample !== want.sample) begin
                    report($sformatf("sample %0d, expected %0d", o_display_sample,
                                     want.sample));
                end
                if (o_second_copy !== want.last) begin
                    report($sformatf("second copy flag %b, expected %b", o_second_copy,
                                     want.last));
                end
            end
        end
    end

    // Send one bin; expectations are queued at the accepting edge.
    task automatic send_bin(input logic signed [27:0] re, input logic signed [27:0] im);
        t_display d;
        int       gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_bin_real = re;
        i_bin_imag = im;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        d.sample = bin_to_display(re, im);
        d.last = 1'b0;
        display_q.push_back(d);
        d.last = 1'b1;
        display_q.push_back(d);
        bins_sent++;
    endtask

    // Lower valid and wait until every expected sample has arrived.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (display_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_floor(input logic [6:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        floor_reg = value;
    endtask

    // Random field, mostly log-spread in magnitude so every dB range is hit.
    function automatic logic signed [27:0] rand_field();
        logic [27:0] v;
        int          bits;
        v = 28'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            return v;
        end
        bits = $urandom_range(0, 27);
        v = v & ((28'd1 << bits) - 28'd1);
        return $urandom_range(0, 1) ? -$signed(v) : $signed(v);
    endfunction

    task automatic test_directed();
        logic signed [27:0] fs;
        fs = 28'(TRANSFORM_LENGTH * 32767);
        send_bin(28'sd0, 28'sd0);
        send_bin(28'sh8000000, 28'sh8000000);
        send_bin(28'sh7ffffff, 28'sh7ffffff);
        send_bin(28'sh8000000, 28'sd0);
        send_bin(28'sd0, 28'sh7ffffff);
        send_bin(fs, 28'sd0);
        send_bin(-fs, 28'sd0);
        send_bin(28'sd0, fs + 28'sd1);
        send_bin(fs - 28'sd1, 28'sd0);
        send_bin(28'sd1, 28'sd0);
        send_bin(28'sd0, -28'sd1);
        send_bin(-28'sd1, -28'sd1);
        send_bin(28'sh5555555, 28'shaaaaaa);
        send_bin(28'shaaaaaaa, 28'sh5555555);
        send_bin(28'sd100, -28'sd200);
        send_bin(28'sd30000, 28'sd4000);
    endtask

    // The floor register at its extremes, reset value included.
    task automatic test_floor_settings();
        logic [6:0] floors[6] = '{7'd0, 7'd1, 7'd120, 7'd127, 7'd45, 7'd90};
        foreach (floors[k]) begin
            write_floor(floors[k]);
            send_bin(28'sd0, 28'sd0);
            send_bin(28'sh7ffffff, 28'sh8000000);
            send_bin(28'sd1, 28'sd0);
            repeat (40) send_bin(rand_field(), rand_field());
        end
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                // Sender holds off until the output side has caught up.
                drain();
                write_floor(7'($urandom_range(0, 127)));
            end
            send_bin(rand_field(), rand_field());
        end
    endtask

    task automatic test_back_to_back(input int count);
        drain();
        idle_on = 1'b0;
        write_floor(7'd60);
        repeat (count) send_bin(rand_field(), rand_field());
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_bin_real = '0;
        i_bin_imag = '0;
        i_stall = 1'b0;
        idle_on = 1'b1;
        errors = 0;
        cycles = 0;
        bins_sent = 0;
        samples_seen = 0;
        stall_left = 0;
        floor_reg = 7'd90;
        full_log2 = log2_fixed(64'(TRANSFORM_LENGTH * 32767) * 64'(TRANSFORM_LENGTH * 32767));
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_floor_settings();
        test_random(1600);
        test_back_to_back(200);
        drain();

        $display("covered %0d bins and %0d display samples over floors 0..127,",
                 bins_sent, samples_seen);
        $display("with zero, full-scale and overrange bins and random stalls on both sides");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
